// ===== hdl/gcpb_pkg.sv =====
// Package for glyph_coverage_pixel_blend: component roles, register indexes,
// blend constants and the per-component blend function. No dependencies.
`default_nettype none

package gcpb_pkg;

    localparam int unsigned COMP_W   = 8;
    localparam int unsigned NUM_COMP = 4;
    localparam int unsigned FMT_W    = 3;
    localparam int unsigned IDX_W    = 2;
    localparam int unsigned CFG_W    = 3;

    localparam logic [COMP_W-1:0] FULL_SCALE    = 8'd255;
    localparam logic [COMP_W-1:0] CHROMA_TARGET = 8'd128;

    localparam logic [IDX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
    localparam logic [IDX_W-1:0] REG_BLEND_ENABLE = 2'd1;

    typedef enum logic [FMT_W-1:0] {
        FMT_GRAY        = 3'd0,
        FMT_THREE       = 3'd1,
        FMT_ALPHA_LAST  = 3'd2,
        FMT_ALPHA_FIRST = 3'd3,
        FMT_LUMA_CHROMA = 3'd4,
        FMT_CHROMA_LUMA = 3'd5
    } t_fmt;

    typedef enum logic [1:0] {
        ROLE_KEEP   = 2'd0,
        ROLE_COLOUR = 2'd1,
        ROLE_CHROMA = 2'd2,
        ROLE_ALPHA  = 2'd3
    } t_role;

    typedef logic [COMP_W-1:0] t_comp;

    // Role of component position k under a given layout
    function automatic t_role role_of(input logic [FMT_W-1:0] fmt, input logic [1:0] k);
        t_role r;
        r = ROLE_KEEP;
        case (fmt)
            FMT_GRAY:        r = (k == 2'd0) ? ROLE_COLOUR : ROLE_KEEP;
            FMT_THREE:       r = (k == 2'd3) ? ROLE_KEEP : ROLE_COLOUR;
            FMT_ALPHA_LAST:  r = (k == 2'd3) ? ROLE_ALPHA : ROLE_COLOUR;
            FMT_ALPHA_FIRST: r = (k == 2'd0) ? ROLE_ALPHA : ROLE_COLOUR;
            FMT_LUMA_CHROMA: r = (k == 2'd0) ? ROLE_COLOUR :
                                 (k == 2'd1) ? ROLE_CHROMA : ROLE_KEEP;
            FMT_CHROMA_LUMA: r = (k == 2'd0) ? ROLE_CHROMA :
                                 (k == 2'd1) ? ROLE_COLOUR : ROLE_KEEP;
            default:         r = ROLE_KEEP;
        endcase
        return r;
    endfunction

    // (c*(255-p) + t*p) / 255, truncated; sum stays below 65535 so
    // (x + (x >> 8) + 1) >> 8 is exact
    function automatic t_comp mix(input t_comp c, input t_comp p, input logic chroma);
        logic [15:0] prod_c;
        logic [15:0] prod_t;
        logic [15:0] x;
        logic [16:0] q;
        prod_c = {8'd0, c} * {8'd0, FULL_SCALE - p};
        prod_t = chroma ? {1'b0, p, 7'd0} : ({p, 8'd0} - {8'd0, p});
        x      = prod_c + prod_t;
        q      = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return q[15:8];
    endfunction

    function automatic t_comp blend_comp(input t_comp c, input t_comp p,
                                         input t_role role, input logic blend_en);
        t_comp r;
        r = c;
        if (p != '0) begin
            case (role)
                ROLE_ALPHA:  r = FULL_SCALE;
                ROLE_COLOUR: r = blend_en ? mix(c, p, 1'b0) : p;
                ROLE_CHROMA: r = blend_en ? mix(c, p, 1'b1) : p;
                default:     r = c;
            endcase
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/glyph_coverage_pixel_blend.sv =====
// Top level: blends one glyph coverage byte onto a four-byte pixel.
// Uses gcpb_pkg for roles, register indexes and the blend function.
//
//   channel   dir  handshake                       payload
//   s_axis    in   s_axis_tvalid / s_axis_tready   coverage, comp0..comp3 (40 bits)
//   m_axis    out  m_axis_tvalid / m_axis_tready   res0..res3 (32 bits)
//   cfg       in   i_cfg_we                        i_cfg_index, i_cfg_data
//
// One item per cycle while m_axis is not stalled; path: input register, then result register.
// Blend logic sits between the two registers: one 8x8 multiplier per lane.
// Synchronous active-low reset clears valids; format resets to gray, blend on.
// A stall on m_axis holds the result; the input register still takes one item.
`default_nettype none

module glyph_coverage_pixel_blend
    import gcpb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [39:0]       s_axis_tdata,  // coverage, comp0, comp1, comp2, comp3
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [31:0]            m_axis_tdata,  // res0, res1, res2, res3
    input  wire logic              i_cfg_we,
    input  wire logic [IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_data
);

    logic [FMT_W-1:0] r_fmt;
    logic             r_blend_en;

    logic             r_in_valid;
    t_comp            r_cov;
    t_comp            r_comp [NUM_COMP];

    logic             r_out_valid;
    logic [31:0]      r_out_data;
    logic [31:0]      n_out_data;

    logic             out_load;
    logic             in_load;

    assign out_load      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || out_load;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt      <= FMT_GRAY;
            r_blend_en <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PIXEL_FORMAT: r_fmt      <= i_cfg_data[FMT_W-1:0];
                REG_BLEND_ENABLE: r_blend_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_cov <= s_axis_tdata[7:0];
            for (int k = 0; k < NUM_COMP; k++) begin
                r_comp[k] <= s_axis_tdata[8*(k+1) +: 8];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_COMP; k++) begin
            n_out_data[8*k +: 8] = blend_comp(r_comp[k], r_cov,
                                              role_of(r_fmt, 2'(k)), r_blend_en);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_in_valid) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

// ===== hdl/gcpb_checker.sv =====
// Port-level checker for glyph_coverage_pixel_blend, bound to the top level.
// Watches the stream ports only; no package needed.
`default_nettype none

module gcpb_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              s_axis_tvalid,
    input wire logic              s_axis_tready,
    input wire logic [39:0]       s_axis_tdata,
    input wire logic              m_axis_tvalid,
    input wire logic              m_axis_tready,
    input wire logic [31:0]       m_axis_tdata
);

    logic s_acc;
    assign s_acc = s_axis_tvalid && s_axis_tready;

    // result holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a ready sink never blocks the source
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("accepted item did not reach output");

    // zero coverage passes the pixel through
    a_zero_cov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && s_axis_tdata[7:0] == 8'd0) ##1 m_axis_tready
        |=> m_axis_tdata == $past(s_axis_tdata[39:8], 2))
        else $error("zero coverage altered pixel");

endmodule

bind glyph_coverage_pixel_blend gcpb_checker u_gcpb_checker (.*);

`default_nettype wire
